// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the link width handshake controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LWHC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define LWHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lwhc_pkg.sv =====
// Types, codes and helper functions of the link width handshake controller.
`default_nettype none
package lwhc_pkg;

  localparam int SeqBits  = 16;  // sequence counter width, 4 to 32
  localparam int TxSeqW   = 16;
  localparam int WidthW   = 3;
  localparam int InDataW  = 16;
  localparam int OutDataW = 32;

  localparam logic [WidthW-1:0] WidthMax = 3'd4;

  typedef enum logic [2:0] {
    CMD_RECEIVE     = 3'd0,
    CMD_NARROW      = 3'd1,
    CMD_RESTORE     = 3'd2,
    CMD_NARROW_DONE = 3'd3,
    CMD_FULL_RESET  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    MSG_ENTRY_REQ = 4'd0,
    MSG_ENTRY_ACK = 4'd1,
    MSG_ENTRY_NAK = 4'd2,
    MSG_EXIT_REQ  = 4'd3,
    MSG_EXIT_ACK  = 4'd4,
    MSG_NAK_DLLP  = 4'd5,
    MSG_L1_REQ    = 4'd6,
    MSG_L1_ACK    = 4'd7,
    MSG_L1_NAK    = 4'd8
  } msg_e;

  // Kind field when no message goes out.
  localparam logic [3:0] KindNone = 4'd0;

  typedef enum logic [4:0] {
    MODE_L0       = 5'b00001,
    MODE_ENTERING = 5'b00010,
    MODE_EXITING  = 5'b00100,
    MODE_NARROWED = 5'b01000,
    MODE_L1_ENTRY = 5'b10000
  } mode_e;

  typedef enum logic [0:0] {
    CFG_PORT_ROLE  = 1'b0,
    CFG_FULL_WIDTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              traffic_queued;
    logic [WidthW-1:0] narrow_width_code;
    logic [WidthW-1:0] rx_width_code;
    logic [3:0]        rx_kind;
    logic [2:0]        cmd;
  } item_t;

  typedef struct packed {
    logic              exit_waiting;
    logic              entry_waiting;
    logic [WidthW-1:0] width_now_code;
    logic [2:0]        link_mode;
    logic [TxSeqW-1:0] tx_sequence;
    logic [WidthW-1:0] tx_width_code;
    logic [3:0]        tx_kind;
    logic              has_message;
  } result_t;

  typedef struct packed {
    logic              port_role;
    logic [WidthW-1:0] full_width_code;
  } cfg_t;

  function automatic logic [WidthW-1:0] clamp_width(logic [WidthW-1:0] w);
    return (w > WidthMax) ? WidthMax : w;
  endfunction

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    case (m)
      MODE_L0:       code = 3'd0;
      MODE_ENTERING: code = 3'd1;
      MODE_EXITING:  code = 3'd2;
      MODE_NARROWED: code = 3'd3;
      MODE_L1_ENTRY: code = 3'd4;
      default:       code = 3'd0;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lwhc_in_stage.sv =====
// Input register of the link width handshake controller.
`default_nettype none
module lwhc_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire lwhc_pkg::item_t item_i,
  input  wire                 advance_i,
  output logic                valid_o,
  output lwhc_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  lwhc_pkg::item_t item_q;
  logic            load;

  // Free when empty or when the held item moves on this cycle.
  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== rtl/lwhc_core.sv =====
// Handshake state and single-step update of the link width handshake controller.
`default_nettype none
`include "assert_macros.svh"
module lwhc_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 advance_i,
  input  wire lwhc_pkg::item_t item_i,
  input  wire lwhc_pkg::cfg_t  cfg_i,
  output lwhc_pkg::result_t   result_o
);

  lwhc_pkg::mode_e                  mode_q, mode_d;
  logic                             entry_q, entry_d;
  logic                             exit_q, exit_d;
  logic                             replay_q, replay_d;
  logic [lwhc_pkg::WidthW-1:0]      width_q, width_d;
  logic [lwhc_pkg::SeqBits-1:0]     seq_q, seq_d;

  logic                             has_msg;
  logic [3:0]                       kind;
  logic [lwhc_pkg::WidthW-1:0]      tx_width;
  logic [lwhc_pkg::TxSeqW-1:0]      tx_seq;
  logic [lwhc_pkg::WidthW-1:0]      rx_w;
  logic [lwhc_pkg::WidthW-1:0]      nar_w;
  logic [lwhc_pkg::WidthW-1:0]      full_w;

  assign rx_w   = lwhc_pkg::clamp_width(item_i.rx_width_code);
  assign nar_w  = lwhc_pkg::clamp_width(item_i.narrow_width_code);
  assign full_w = lwhc_pkg::clamp_width(cfg_i.full_width_code);

  always_comb begin
    mode_d   = mode_q;
    entry_d  = entry_q;
    exit_d   = exit_q;
    replay_d = replay_q;
    width_d  = width_q;
    seq_d    = seq_q;
    has_msg  = 1'b0;
    kind     = lwhc_pkg::KindNone;
    tx_width = '0;
    tx_seq   = '0;
    case (item_i.cmd)
      lwhc_pkg::CMD_RECEIVE: begin
        case (item_i.rx_kind)
          lwhc_pkg::MSG_ENTRY_REQ: begin
            has_msg = 1'b1;
            // Refuse while a replay is pending or an upstream port has traffic.
            if (replay_q || (item_i.traffic_queued && cfg_i.port_role)) begin
              kind = lwhc_pkg::MSG_ENTRY_NAK;
            end else begin
              mode_d   = lwhc_pkg::MODE_ENTERING;
              kind     = lwhc_pkg::MSG_ENTRY_ACK;
              tx_width = rx_w;
            end
          end
          lwhc_pkg::MSG_ENTRY_ACK: begin
            entry_d = 1'b0;
          end
          lwhc_pkg::MSG_ENTRY_NAK: begin
            entry_d = 1'b0;
            mode_d  = lwhc_pkg::MODE_L0;
          end
          lwhc_pkg::MSG_EXIT_REQ: begin
            // Upstream yields on a simultaneous exit.
            if (exit_q && cfg_i.port_role) begin
              exit_d = 1'b0;
            end
            mode_d   = lwhc_pkg::MODE_EXITING;
            has_msg  = 1'b1;
            kind     = lwhc_pkg::MSG_EXIT_ACK;
            tx_width = rx_w;
          end
          lwhc_pkg::MSG_EXIT_ACK: begin
            exit_d = 1'b0;
          end
          lwhc_pkg::MSG_NAK_DLLP: begin
            replay_d = 1'b1;
          end
          lwhc_pkg::MSG_L1_REQ: begin
            has_msg = 1'b1;
            if (mode_q == lwhc_pkg::MODE_NARROWED) begin
              kind = lwhc_pkg::MSG_L1_NAK;
            end else begin
              mode_d = lwhc_pkg::MODE_L1_ENTRY;
              kind   = lwhc_pkg::MSG_L1_ACK;
            end
          end
          default: begin
          end
        endcase
      end
      lwhc_pkg::CMD_NARROW: begin
        entry_d  = 1'b1;
        mode_d   = lwhc_pkg::MODE_ENTERING;
        has_msg  = 1'b1;
        kind     = lwhc_pkg::MSG_ENTRY_REQ;
        tx_width = nar_w;
        tx_seq   = lwhc_pkg::TxSeqW'(seq_q);
        seq_d    = seq_q + lwhc_pkg::SeqBits'(1);
      end
      lwhc_pkg::CMD_RESTORE: begin
        exit_d   = 1'b1;
        mode_d   = lwhc_pkg::MODE_EXITING;
        has_msg  = 1'b1;
        kind     = lwhc_pkg::MSG_EXIT_REQ;
        tx_width = full_w;
        tx_seq   = lwhc_pkg::TxSeqW'(seq_q);
        seq_d    = seq_q + lwhc_pkg::SeqBits'(1);
      end
      lwhc_pkg::CMD_NARROW_DONE: begin
        mode_d  = lwhc_pkg::MODE_NARROWED;
        width_d = nar_w;
      end
      lwhc_pkg::CMD_FULL_RESET: begin
        mode_d   = lwhc_pkg::MODE_L0;
        width_d  = full_w;
        replay_d = 1'b0;
        entry_d  = 1'b0;
        exit_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lwhc_pkg::MODE_L0;
      entry_q  <= 1'b0;
      exit_q   <= 1'b0;
      replay_q <= 1'b0;
      width_q  <= lwhc_pkg::WidthMax;
      seq_q    <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      entry_q  <= entry_d;
      exit_q   <= exit_d;
      replay_q <= replay_d;
      width_q  <= width_d;
      seq_q    <= seq_d;
    end
  end

  always_comb begin
    result_o.has_message    = has_msg;
    result_o.tx_kind        = kind;
    result_o.tx_width_code  = tx_width;
    result_o.tx_sequence    = tx_seq;
    result_o.link_mode      = lwhc_pkg::mode_code(mode_d);
    result_o.width_now_code = width_d;
    result_o.entry_waiting  = entry_d;
    result_o.exit_waiting   = exit_d;
  end

  `LWHC_ASSERT_NEXT(a_full_reset_clears, clk_i, rst_ni,
    advance_i && (item_i.cmd == lwhc_pkg::CMD_FULL_RESET),
    !entry_q && !exit_q && !replay_q, "full reset left a pending flag set")
  `LWHC_ASSERT_NEXT(a_seq_step, clk_i, rst_ni,
    advance_i && ((item_i.cmd == lwhc_pkg::CMD_NARROW) ||
    (item_i.cmd == lwhc_pkg::CMD_RESTORE)),
    seq_q == lwhc_pkg::SeqBits'($past(seq_q) + lwhc_pkg::SeqBits'(1)),
    "sequence counter did not step")

endmodule
`default_nettype wire

// ===== rtl/lwhc_out_stage.sv =====
// Result register of the link width handshake controller.
`default_nettype none
module lwhc_out_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 advance_i,
  input  wire lwhc_pkg::result_t result_i,
  input  wire                 ready_i,
  output logic                valid_o,
  output lwhc_pkg::result_t   result_o
);

  logic              valid_q, valid_d;
  lwhc_pkg::result_t result_q;

  assign valid_d = advance_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

// ===== rtl/link_width_handshake_controller_core.sv =====
// Top level of the link width handshake controller: one port's side of the width handshake.
//
// Each input transaction carries one event (received message, local narrow or
// restore request, narrowing done, full reset) and yields exactly one result
// transaction: the message to send, if any, and the link state after the event.
// An event lands in the input register, then the update logic moves the state
// and fills the result register, so one event per cycle is taken while the
// result side keeps up. Each event passes the input register and then the
// result register before its result transaction completes. Throughput
// stays at one transaction per cycle as long as the result side keeps
// m_axis_tready high; with both registers full, s_axis_tready follows
// m_axis_tready. Write port_role (index 0) and full_width_code (index 1) through
// the cfg channel only while no event is in flight; the channel is always ready.
// Width codes above x16 saturate to x16.
`default_nettype none
`include "assert_macros.svh"
module link_width_handshake_controller_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [0:0]  cfg_index_i,
  input  wire  [2:0]  cfg_data_i,
  // event stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [6:3] rx_kind, [9:7] rx_width_code, [12:10] narrow_width_code,
  // [13] traffic_queued, [15:14] zero
  input  wire  [15:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [0] has_message, [4:1] tx_kind, [7:5] tx_width_code, [23:8] tx_sequence,
  // [26:24] link_mode, [29:27] width_now_code, [30] entry_waiting, [31] exit_waiting
  output logic [31:0] m_axis_tdata
);

  lwhc_pkg::cfg_t    cfg_q;
  lwhc_pkg::item_t   in_item, held_item;
  lwhc_pkg::result_t step_result, out_result;
  logic              held_valid;
  logic              advance;
  logic              cfg_write;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port_role       <= 1'b0;
      cfg_q.full_width_code <= lwhc_pkg::WidthMax;
    end else if (cfg_write) begin
      case (cfg_index_i)
        lwhc_pkg::CFG_PORT_ROLE:  cfg_q.port_role       <= cfg_data_i[0];
        lwhc_pkg::CFG_FULL_WIDTH: cfg_q.full_width_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Unpack the event transaction.
  always_comb begin
    in_item.cmd               = s_axis_tdata[2:0];
    in_item.rx_kind           = s_axis_tdata[6:3];
    in_item.rx_width_code     = s_axis_tdata[9:7];
    in_item.narrow_width_code = s_axis_tdata[12:10];
    in_item.traffic_queued    = s_axis_tdata[13];
  end

  // Step the held event when the result register is empty or being drained.
  assign advance = held_valid && (!m_axis_tvalid || m_axis_tready);

  lwhc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  lwhc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .cfg_i     (cfg_q),
    .result_o  (step_result)
  );

  lwhc_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .result_i  (step_result),
    .ready_i   (m_axis_tready),
    .valid_o   (m_axis_tvalid),
    .result_o  (out_result)
  );

  // Pack the result transaction.
  always_comb begin
    m_axis_tdata[0]     = out_result.has_message;
    m_axis_tdata[4:1]   = out_result.tx_kind;
    m_axis_tdata[7:5]   = out_result.tx_width_code;
    m_axis_tdata[23:8]  = out_result.tx_sequence;
    m_axis_tdata[26:24] = out_result.link_mode;
    m_axis_tdata[29:27] = out_result.width_now_code;
    m_axis_tdata[30]    = out_result.entry_waiting;
    m_axis_tdata[31]    = out_result.exit_waiting;
  end

  `LWHC_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, m_axis_tvalid,
    "stepped event produced no result")
  `LWHC_ASSERT_NEXT(a_held_item_stays, clk_i, rst_ni, held_valid && !advance,
    held_valid && $stable(held_item), "held event lost while stalled")

endmodule
`default_nettype wire
